// ----- hdl/sts_pkg.sv -----
`timescale 1ns / 1ps

package sts_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int OUT_BITS          = 16;
	localparam int PREFIX_BITS       = 48;
	localparam int KEYWORDS          = 9;
	localparam int FIFO_DEPTH        = 4;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_NUM   = 2'd1,
		MODE_IDENT = 2'd2
	} scan_mode_t;

	typedef logic [4:0] kind_t;

	localparam kind_t KIND_NUMBER = 5'd0;
	localparam kind_t KIND_IDENT  = 5'd1;
	localparam kind_t KIND_KW_IF  = 5'd2;
	localparam kind_t KIND_PLUS   = 5'd11;
	localparam kind_t KIND_MINUS  = 5'd12;
	localparam kind_t KIND_STAR   = 5'd13;
	localparam kind_t KIND_SLASH  = 5'd14;
	localparam kind_t KIND_EQUAL  = 5'd15;
	localparam kind_t KIND_LPAREN = 5'd16;
	localparam kind_t KIND_RPAREN = 5'd17;
	localparam kind_t KIND_LBRACE = 5'd18;
	localparam kind_t KIND_RBRACE = 5'd19;
	localparam kind_t KIND_LBRACK = 5'd20;
	localparam kind_t KIND_RBRACK = 5'd21;
	localparam kind_t KIND_COMMA  = 5'd22;
	localparam kind_t KIND_COLON  = 5'd23;
	localparam kind_t KIND_SEMI   = 5'd24;
	localparam kind_t KIND_EOF    = 5'd25;
	localparam kind_t KIND_ERROR  = 5'd26;

	// keyword spellings, right aligned, first byte highest
	localparam logic [PREFIX_BITS-1:0] KW_TEXT [KEYWORDS] = '{
		48'h0000_0000_6966,     // if
		48'h0000_656C_7365,     // else
		48'h0000_5452_5545,     // TRUE
		48'h0046_414C_5345,     // FALSE
		48'h0077_6869_6C65,     // while
		48'h7265_7475_726E,     // return
		48'h0000_6675_6E63,     // func
		48'h0000_0076_6172,     // var
		48'h0000_6563_686F      // echo
	};

	typedef struct packed {
		kind_t                kind;
		logic [OUT_BITS-1:0]  start;
		logic [OUT_BITS-1:0]  length;
		logic                 last;
	} token_t;

	function automatic logic [OUT_BITS-1:0] sat_out(input logic [31:0] v);
		sat_out = (v > 32'd65535) ? 16'hFFFF : v[OUT_BITS-1:0];
	endfunction

	// single-byte tokens; anything unlisted is an error
	function automatic kind_t punct_kind(input logic [7:0] c);
		case (c)
			8'h2B:   punct_kind = KIND_PLUS;
			8'h2D:   punct_kind = KIND_MINUS;
			8'h2A:   punct_kind = KIND_STAR;
			8'h2F:   punct_kind = KIND_SLASH;
			8'h3D:   punct_kind = KIND_EQUAL;
			8'h28:   punct_kind = KIND_LPAREN;
			8'h29:   punct_kind = KIND_RPAREN;
			8'h7B:   punct_kind = KIND_LBRACE;
			8'h7D:   punct_kind = KIND_RBRACE;
			8'h5B:   punct_kind = KIND_LBRACK;
			8'h5D:   punct_kind = KIND_RBRACK;
			8'h2C:   punct_kind = KIND_COMMA;
			8'h3A:   punct_kind = KIND_COLON;
			8'h3B:   punct_kind = KIND_SEMI;
			default: punct_kind = KIND_ERROR;
		endcase
	endfunction

endpackage

// ----- hdl/script_token_scanner.sv -----
`timescale 1ns / 1ps

// Streaming lexer: one source byte per transfer on the slave side, tokens on the
// master side. Whitespace (space, newline, tab) is skipped; digit runs become
// number tokens; a letter starts an identifier (letters, digits, underscore)
// that is matched case-sensitively against nine keywords when it ends; fourteen
// punctuation bytes give one-byte tokens; a zero byte gives end of file and
// resets the offset; anything else is an error token. A byte that ends a run
// can yield two tokens (the run, then its own), and tlast marks the final
// token caused by each byte. Start and length saturate at 65535; the internal
// offset saturates at 2^POSITION_BITS-1. A byte is registered on acceptance,
// scanned from that register once the token queue has room, and its tokens go
// into that queue, which feeds the master side. One byte per cycle is sustained
// while the four-entry token queue has room for two; bytes yielding two tokens
// drain at the master side's single-token-per-cycle rate, which limits rate.
module script_token_scanner #(
	parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [4:0] token_kind, [20:5] token_start,
	                                    // [36:21] token_length, [39:37] zero
	output logic        m_axis_tlast    // last_of_run
);
	import sts_pkg::*;

	localparam int PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// scanner state
	scan_mode_t                mode_q, mode_d;
	logic [POSITION_BITS-1:0]  pos_q, pos_d;
	logic [POSITION_BITS-1:0]  start_q, start_d;
	logic [PREFIX_BITS-1:0]    prefix_q, prefix_d;
	logic                      too_long_q, too_long_d;

	// token queue
	token_t               fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]  wr_q, rd_q;
	logic [CNT_BITS-1:0]  count_q;

	logic        consume, pop;
	logic        is_digit, is_letter, is_space, is_under, is_cont;
	logic        run_open, run_ends;
	kind_t       run_kind;
	token_t      run_tok, own_tok, tok0, tok1;
	logic        own_valid;
	logic [1:0]  n_push;

	// Stall the scan unless the queue can take two tokens.
	assign consume       = valid_s1 && (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || consume;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// byte classes
	assign is_digit  = (byte_s1 >= 8'h30) && (byte_s1 <= 8'h39);
	assign is_letter = ((byte_s1 >= 8'h41) && (byte_s1 <= 8'h5A)) ||
	                   ((byte_s1 >= 8'h61) && (byte_s1 <= 8'h7A));
	assign is_space  = (byte_s1 == 8'h20) || (byte_s1 == 8'h0A) || (byte_s1 == 8'h09);
	assign is_under  = (byte_s1 == 8'h5F);
	assign run_open  = (mode_q != MODE_IDLE);
	assign is_cont   = ((mode_q == MODE_NUM) && is_digit) ||
	                   ((mode_q == MODE_IDENT) && (is_letter || is_digit || is_under));
	assign run_ends  = run_open && !is_cont;

	// kind of the pending run; keyword compares run side by side
	always_comb begin
		run_kind = (mode_q == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
		if (mode_q == MODE_IDENT && !too_long_q) begin
			for (int i = 0; i < KEYWORDS; i++) begin
				if (prefix_q == KW_TEXT[i]) begin
					run_kind = KIND_KW_IF + kind_t'(i);
				end
			end
		end
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (!is_cont) begin
			if (is_digit) begin
				mode_d = MODE_NUM;
			end else if (is_letter) begin
				mode_d = MODE_IDENT;
			end else begin
				mode_d = MODE_IDLE;
			end
		end
	end

	// tokens and remaining state
	always_comb begin
		start_d    = start_q;
		prefix_d   = prefix_q;
		too_long_d = too_long_q;
		pos_d      = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;

		run_tok.kind   = run_kind;
		run_tok.start  = sat_out(32'(start_q));
		run_tok.length = sat_out(32'(pos_q - start_q));
		run_tok.last   = 1'b0;

		own_valid      = 1'b0;
		own_tok.kind   = punct_kind(byte_s1);
		own_tok.start  = sat_out(32'(pos_q));
		own_tok.length = 16'd1;
		own_tok.last   = 1'b1;

		if (is_cont) begin
			if (mode_q == MODE_IDENT) begin
				if (prefix_q[PREFIX_BITS-1 -: 8] != 8'd0) begin
					too_long_d = 1'b1;
				end
				prefix_d = {prefix_q[PREFIX_BITS-9:0], byte_s1};
			end
		end else if (is_digit || is_letter) begin
			start_d    = pos_q;
			prefix_d   = PREFIX_BITS'(byte_s1);
			too_long_d = 1'b0;
		end else if (byte_s1 == 8'h00) begin
			own_valid    = 1'b1;
			own_tok.kind = KIND_EOF;
			pos_d        = '0;
			start_d      = '0;
			prefix_d     = '0;
			too_long_d   = 1'b0;
		end else if (!is_space) begin
			own_valid = 1'b1;
		end

		run_tok.last = !own_valid;
		if (run_ends) begin
			tok0 = run_tok;
			tok1 = own_tok;
		end else begin
			tok0 = own_tok;
			tok1 = own_tok;
		end
		n_push = 2'(run_ends) + 2'(own_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pos_q      <= '0;
			start_q    <= '0;
			prefix_q   <= '0;
			too_long_q <= 1'b0;
		end else if (consume) begin
			mode_q     <= mode_d;
			pos_q      <= pos_d;
			start_q    <= start_d;
			prefix_q   <= prefix_d;
			too_long_q <= too_long_d;
		end
	end

	// token queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (consume) begin
				wr_q <= wr_q + PTR_BITS'(n_push);
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + CNT_BITS'(consume ? n_push : 2'd0) - CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (consume && n_push != 2'd0) begin
			fifo_q[wr_q] <= tok0;
		end
		if (consume && n_push == 2'd2) begin
			fifo_q[wr_q + 1'b1] <= tok1;
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {3'b000, fifo_q[rd_q].length, fifo_q[rd_q].start,
	                        fifo_q[rd_q].kind};
	assign m_axis_tlast  = fifo_q[rd_q].last;

	// queue occupancy never exceeds its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(FIFO_DEPTH))
		else $error("token queue overfilled");

	// end of text leaves the scanner idle at offset zero
	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && byte_s1 == 8'h00) |=> (mode_q == MODE_IDLE && pos_q == '0))
		else $error("end of text did not reset scanner");

	// a held byte is not overwritten while the scan stalls
	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !consume) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte lost");

	// whitespace while idle produces no token
	a_idle_space: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && mode_q == MODE_IDLE && is_space) |-> (n_push == 2'd0))
		else $error("token from idle whitespace");

endmodule
